// ===== rtl/yrc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared types and constants for the YUYV to RGB24 converter.
// ----------------------------------------------------------------------------
package yrc_pkg;

   // Fixed field widths
   localparam int POS_W    = 14;  // byte position inside a source row
   localparam int STRIDE_W = 15;  // stride and pair byte span, up to 16384
   localparam int PX_W     = 14;  // clamped pixel count per row
   localparam int ROWCFG_W = 14;  // frame row count compare width
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [STRIDE_W-1:0] STRIDE_MIN = 15'd4;
   localparam logic [STRIDE_W-1:0] STRIDE_CAP = 15'd16384;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_ROW_PIXELS = 2'd0;
   localparam logic [1:0] REG_ROW_STRIDE = 2'd1;
   localparam logic [1:0] REG_FRAME_ROWS = 2'd2;

   localparam logic [12:0] ROW_PIXELS_RST = 13'd640;
   localparam logic [14:0] ROW_STRIDE_RST = 15'd1280;
   localparam logic [12:0] FRAME_ROWS_RST = 13'd480;

   // Byte lane inside a Y0 U Y1 V group
   localparam logic [1:0] LANE_Y0 = 2'd0;
   localparam logic [1:0] LANE_U  = 2'd1;
   localparam logic [1:0] LANE_Y1 = 2'd2;
   localparam logic [1:0] LANE_V  = 2'd3;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       second_of_pair;
      logic       row_last;
      logic       frame_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [12:0] row_pixels;
      logic [14:0] row_stride_bytes;
      logic [12:0] frame_rows;
   } cfg_regs_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       row_last;
      logic       frame_last;
   } pair_type;

endpackage

// ===== rtl/yrc_csr.sv =====
// ----------------------------------------------------------------------------
// yrc_csr
// APB register file: row_pixels, row_stride_bytes, frame_rows.
// ----------------------------------------------------------------------------
module yrc_csr
   import yrc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_regs_type      cfg
);

   logic        wr_en;
   logic [1:0]  reg_idx;
   cfg_regs_type cfg_ff, cfg_in;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ROW_PIXELS: cfg_in.row_pixels       = pwdata[12:0];
            REG_ROW_STRIDE: cfg_in.row_stride_bytes = pwdata[14:0];
            REG_FRAME_ROWS: cfg_in.frame_rows       = pwdata[12:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_pixels       <= ROW_PIXELS_RST;
         cfg_ff.row_stride_bytes <= ROW_STRIDE_RST;
         cfg_ff.frame_rows       <= FRAME_ROWS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ROW_PIXELS: prdata = {19'd0, cfg_ff.row_pixels};
         REG_ROW_STRIDE: prdata = {17'd0, cfg_ff.row_stride_bytes};
         REG_FRAME_ROWS: prdata = {19'd0, cfg_ff.frame_rows};
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/yrc_tracker.sv =====
// ----------------------------------------------------------------------------
// yrc_tracker
// Row/byte position tracking, Y0/U/Y1 holding and the pair register.
// ----------------------------------------------------------------------------
module yrc_tracker
   import yrc_pkg::*;
#(
   parameter int MAX_ROW_PIXELS = 4096,
   parameter int MAX_FRAME_ROWS = 4096
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_regs_type    cfg,
   input  logic            take,
   input  req_payload_type req_data,
   output logic            pair_valid,
   output pair_type        pair
);

   localparam int ROW_W = (MAX_FRAME_ROWS > 1) ? $clog2(MAX_FRAME_ROWS) : 1;
   localparam logic [PX_W-1:0]     MAX_PX   = PX_W'(MAX_ROW_PIXELS);
   localparam logic [ROWCFG_W-1:0] MAX_ROWS = ROWCFG_W'(MAX_FRAME_ROWS);

   logic [POS_W-1:0]    pos_ff, pos_in, pos_cur;
   logic [ROW_W-1:0]    row_ff, row_in, row_cur;
   logic [7:0]          y0_ff, y0_in, u_ff, u_in, y1_ff, y1_in;
   logic                pair_valid_ff, pair_valid_in;
   pair_type            pair_ff, pair_in;

   logic [PX_W-1:0]     px;
   logic [STRIDE_W-1:0] pair_bytes, stride_a, stride_b, stride;
   logic [ROWCFG_W-1:0] rows_a, rows_b;
   logic [ROW_W:0]      rows;
   logic [STRIDE_W-1:0] pos_next;
   logic [ROW_W:0]      row_next;
   logic                in_pairs, row_end, frame_wrap, rlast;

   // Effective configuration
   always_comb begin
      px         = ({1'b0, cfg.row_pixels} > MAX_PX) ? MAX_PX : {1'b0, cfg.row_pixels};
      pair_bytes = {px[PX_W-1:1], 2'b00};
      stride_a   = (cfg.row_stride_bytes < pair_bytes) ? pair_bytes : cfg.row_stride_bytes;
      stride_b   = (stride_a < STRIDE_MIN) ? STRIDE_MIN : stride_a;
      stride     = (stride_b > STRIDE_CAP) ? STRIDE_CAP : stride_b;
      rows_a     = (cfg.frame_rows == '0) ? ROWCFG_W'(1) : {1'b0, cfg.frame_rows};
      rows_b     = (rows_a > MAX_ROWS) ? MAX_ROWS : rows_a;
      rows       = rows_b[ROW_W:0];
   end

   always_comb begin
      pos_cur    = req_data.frame_start ? '0 : pos_ff;
      row_cur    = req_data.frame_start ? '0 : row_ff;
      in_pairs   = {1'b0, pos_cur} < pair_bytes;
      pos_next   = {1'b0, pos_cur} + STRIDE_W'(1);
      row_end    = pos_next >= stride;
      row_next   = {1'b0, row_cur} + (ROW_W+1)'(1);
      frame_wrap = row_next >= rows;
      rlast      = pos_next == pair_bytes;

      pos_in        = pos_ff;
      row_in        = row_ff;
      y0_in         = y0_ff;
      u_in          = u_ff;
      y1_in         = y1_ff;
      pair_valid_in = 1'b0;
      pair_in       = pair_ff;

      if (take) begin
         pos_in = row_end ? '0 : pos_next[POS_W-1:0];
         row_in = row_cur;
         if (row_end) begin
            row_in = frame_wrap ? '0 : row_next[ROW_W-1:0];
         end
         if (in_pairs) begin
            case (pos_cur[1:0])
               LANE_Y0: y0_in = req_data.src_byte;
               LANE_U:  u_in  = req_data.src_byte;
               LANE_Y1: y1_in = req_data.src_byte;
               LANE_V: begin
                  pair_valid_in       = 1'b1;
                  pair_in.luma_first  = y0_ff;
                  pair_in.luma_second = y1_ff;
                  pair_in.chroma_blue = u_ff;
                  pair_in.chroma_red  = req_data.src_byte;
                  pair_in.row_last    = rlast;
                  pair_in.frame_last  = rlast && ({1'b0, row_cur} == rows - (ROW_W+1)'(1));
               end
               default: pair_valid_in = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         row_ff        <= '0;
         y0_ff         <= '0;
         u_ff          <= '0;
         y1_ff         <= '0;
         pair_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         row_ff        <= row_in;
         y0_ff         <= y0_in;
         u_ff          <= u_in;
         y1_ff         <= y1_in;
         pair_valid_ff <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair_valid = pair_valid_ff;
   assign pair       = pair_ff;

endmodule

// ===== rtl/yrc_convert.sv =====
// ----------------------------------------------------------------------------
// yrc_convert
// Color math for one Y0/U/Y1/V pair: two clamped RGB pixels.
// ----------------------------------------------------------------------------
module yrc_convert
   import yrc_pkg::*;
(
   input  pair_type        pair,
   output rsp_payload_type pix_first,
   output rsp_payload_type pix_second
);

   logic signed [17:0] u_x, v_x, r_d, g_d, b_d, y0_x, y1_x;

   function automatic logic [7:0] clamp8(input logic signed [17:0] x);
      logic [7:0] res;
      if (x < 0) begin
         res = 8'd0;
      end else if (x > 18'sd255) begin
         res = 8'd255;
      end else begin
         res = x[7:0];
      end
      return res;
   endfunction

   always_comb begin
      u_x  = $signed({10'd0, pair.chroma_blue}) - 18'sd128;
      v_x  = $signed({10'd0, pair.chroma_red}) - 18'sd128;
      y0_x = $signed({10'd0, pair.luma_first});
      y1_x = $signed({10'd0, pair.luma_second});
      // floor shifts: >>> on signed values
      r_d  = (v_x + (v_x <<< 1)) >>> 1;
      g_d  = ((u_x + (u_x <<< 1)) + ((v_x <<< 2) + (v_x <<< 1))) >>> 3;
      b_d  = ((u_x <<< 7) + u_x) >>> 6;

      pix_first.red            = clamp8(y0_x + r_d);
      pix_first.green          = clamp8(y0_x - g_d);
      pix_first.blue           = clamp8(y0_x + b_d);
      pix_first.second_of_pair = 1'b0;
      pix_first.row_last       = 1'b0;
      pix_first.frame_last     = 1'b0;

      pix_second.red            = clamp8(y1_x + r_d);
      pix_second.green          = clamp8(y1_x - g_d);
      pix_second.blue           = clamp8(y1_x + b_d);
      pix_second.second_of_pair = 1'b1;
      pix_second.row_last       = pair.row_last;
      pix_second.frame_last     = pair.frame_last;
   end

endmodule

// ===== rtl/yrc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// yrc_out_fifo
// Four-entry pixel queue; takes a pixel pair per write, gives one per transfer.
// ----------------------------------------------------------------------------
module yrc_out_fifo
   import yrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type pix_first,
   input  rsp_payload_type pix_second,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   output logic [2:0]      level
);

   rsp_payload_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign pop = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd2 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + (push ? 3'd2 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff]         <= pix_first;
         mem_ff[wr_ptr_ff + 2'd1]  <= pix_second;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

// ===== rtl/yuyv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_core
// YUYV byte stream in, RGB24 pixels out, with row stride and frame tracking.
// ----------------------------------------------------------------------------
// Path: a V byte passes through the pair register, then the pixel queue, before
//   its Y0 pixel shows on rsp_data; the Y1 pixel follows next.
// Throughput: one source byte per cycle while the queue drains; two pixels per
//   four-byte group, limited by the single rsp transfer per cycle out of the queue.
// Reset (synchronous): clears byte/row position, held Y0/U/Y1, the pair valid
//   flag and the queue; registers return to 640 / 1280 / 480.
module yuyv_to_rgb_converter_core
   import yrc_pkg::*;
#(
   parameter int MAX_ROW_PIXELS = 4096,
   parameter int MAX_FRAME_ROWS = 4096
)
(
   input  logic              clock,
   input  logic              reset,
   // source byte channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_payload_type   req_data,
   // pixel channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_regs_type    cfg;
   logic            take;
   logic            pair_valid;
   pair_type        pair;
   rsp_payload_type pix_first, pix_second;
   logic [2:0]      level;

   assign pready = 1'b1;

   // Byte transfer only when the queue can absorb a full pair on top of the
   // pair already sitting in the pair register. Independent of payload, so
   // non-V bytes also wait; the queue never holds more than its four entries.
   assign req_ready = ({1'b0, level} + (pair_valid ? 4'd2 : 4'd0)) <= 4'd2;
   assign take      = req_valid & req_ready;

   yrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // Position tracking and capture of each completed Y0 U Y1 V group
   yrc_tracker #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
      .MAX_FRAME_ROWS (MAX_FRAME_ROWS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .take       (take),
      .req_data   (req_data),
      .pair_valid (pair_valid),
      .pair       (pair)
   );

   // Shifts/adds only: 3v, 3u+6v, 129u, then clamp
   yrc_convert u_convert (
      .pair       (pair),
      .pix_first  (pix_first),
      .pix_second (pix_second)
   );

   // Pixel queue: both pixels written at once, drained one per transfer
   yrc_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (pair_valid),
      .pix_first  (pix_first),
      .pix_second (pix_second),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .level      (level)
   );

endmodule

// ===== verif/tb_yuyv_to_rgb_converter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_converter_core
// Self-checking bench for the YUYV to RGB24 converter. Streams source bytes
// with random gaps against random back-pressure on the pixel side. Predicts
// every pixel and its row/frame flags. Moves the row geometry registers
// through legal, clamped and out-of-range settings.
// ----------------------------------------------------------------------------
module tb_yuyv_to_rgb_converter_core;
   import yrc_pkg::*;

   localparam int PIXELS_CAP  = 4096;   // matches the core's default parameter
   localparam int ROWS_CAP    = 4096;
   localparam int BYTES_CAP   = 16384;  // stride ceiling
   localparam int CHROMA_ZERO = 128;
   localparam int ITEM_TARGET = 450;    // source bytes to send over the whole run
   localparam int MIN_PHASES  = 10;     // every fixed geometry gets its turn
   localparam int MAX_PHASES  = 40;
   localparam int MAX_GAP     = 12;
   localparam int SETTLE      = 8;      // margin for the pair register and pixel queue to empty
   localparam int DRAIN_LIMIT = 5000;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 10;

   localparam logic [14:0] PX_MASK   = 15'h1FFF;
   localparam logic [14:0] WIDE_MASK = 15'h7FFF;

   typedef enum logic {ROW_XFER, ROW_WRITE} dir_kind_type;

   // One directed step: either a byte transfer or a register write.
   // known: the pixel pair is typed in here rather than predicted.
   typedef struct packed {
      dir_kind_type    kind;
      logic [1:0]      reg_sel;
      logic [14:0]     reg_val;
      logic [7:0]      src_byte;
      logic            frame_start;
      logic            known;
      rsp_payload_type pix_a;
      rsp_payload_type pix_b;
   } dir_row_type;

   localparam rsp_payload_type NO_PIX = '0;
   localparam int DIR_ROWS = 27;

   // Neutral chroma, then both chroma extremes (clamping on every channel),
   // then a 3-pixel row (odd width) with 2 padding bytes, 2 rows per frame.
   dir_row_type dir_tab [DIR_ROWS] = '{
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b1, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd128, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd128, 1'b0, 1'b1,
        '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0}},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b1,
        '{8'd255, 8'd113, 8'd255, 1'b0, 1'b0, 1'b0},
        '{8'd190, 8'd0, 8'd255, 1'b1, 1'b0, 1'b0}},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b0, 1'b1,
        '{8'd63, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0},
        '{8'd0, 8'd144, 8'd0, 1'b1, 1'b0, 1'b0}},
      '{ROW_WRITE, REG_ROW_PIXELS, 15'd3, 8'd0, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_WRITE, REG_ROW_STRIDE, 15'd6, 8'd0, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_WRITE, REG_FRAME_ROWS, 15'd2, 8'd0, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd16,  1'b1, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd90,  1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd235, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd240, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd170, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd85,  1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd60,  1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd200, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd180, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd30,  1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd255, 1'b0, 1'b0, NO_PIX, NO_PIX},
      '{ROW_XFER, REG_ROW_PIXELS, 15'd0, 8'd0,   1'b0, 1'b0, NO_PIX, NO_PIX}
   };

   // DUT ports, all inputs known from time zero
   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_payload_type   req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_payload_type   rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Bench copy of the registers and the stream position
   logic [12:0] cfg_px     = ROW_PIXELS_RST;
   logic [14:0] cfg_stride = ROW_STRIDE_RST;
   logic [12:0] cfg_rows   = FRAME_ROWS_RST;
   int          at_byte    = 0;
   int          at_row     = 0;
   logic [7:0]  y0_hold    = '0;
   logic [7:0]  u_hold     = '0;
   logic [7:0]  y1_hold    = '0;

   rsp_payload_type pending_pixels [$];

   int unsigned error_count    = 0;
   int unsigned pixels_checked = 0;
   int unsigned bytes_sent     = 0;
   int unsigned span_bytes     = 0;
   int unsigned reg_writes     = 0;
   int unsigned cycle_count    = 0;
   int unsigned stall_left     = 0;
   logic        stall_mode     = 1'b0;

   yuyv_to_rgb_converter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] clamp_comp(input int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return x[7:0];
   endfunction

   function automatic string pix_str(input rsp_payload_type p);
      return $sformatf("rgb %0d,%0d,%0d second %b row_last %b frame_last %b",
                       p.red, p.green, p.blue, p.second_of_pair, p.row_last,
                       p.frame_last);
   endfunction

   function void flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Takes one source byte through the bench's copy of the stream state.
   // Returns the number of pixels it yields; in_span is low for padding.
   function automatic int convert_byte(input logic [7:0] b, input logic fs,
                                       output rsp_payload_type pa,
                                       output rsp_payload_type pb,
                                       output logic in_span);
      int         px, pair_bytes, stride, rows;
      int         u, v, dr, dg, db;
      logic [1:0] lane;
      logic       rlast;
      px = (int'(cfg_px) > PIXELS_CAP) ? PIXELS_CAP : int'(cfg_px);
      pair_bytes = (px / 2) * 4;
      stride = int'(cfg_stride);
      if (stride < pair_bytes) stride = pair_bytes;
      if (stride < 4) stride = 4;
      if (stride > BYTES_CAP) stride = BYTES_CAP;
      rows = int'(cfg_rows);
      if (rows == 0) rows = 1;
      if (rows > ROWS_CAP) rows = ROWS_CAP;
      pa = '0;
      pb = '0;
      convert_byte = 0;

      if (fs) begin
         at_byte = 0;
         at_row = 0;
      end
      in_span = (at_byte < pair_bytes);
      lane = at_byte[1:0];
      if (in_span) begin
         case (lane)
            LANE_Y0: y0_hold = b;
            LANE_U:  u_hold = b;
            LANE_Y1: y1_hold = b;
            default: begin
               // floor shifts on signed ints
               u = int'(u_hold) - CHROMA_ZERO;
               v = int'(b) - CHROMA_ZERO;
               dr = (3 * v) >>> 1;
               dg = (3 * u + 6 * v) >>> 3;
               db = (129 * u) >>> 6;
               rlast = (at_byte + 1 == pair_bytes);
               pa.red   = clamp_comp(int'(y0_hold) + dr);
               pa.green = clamp_comp(int'(y0_hold) - dg);
               pa.blue  = clamp_comp(int'(y0_hold) + db);
               pb.red   = clamp_comp(int'(y1_hold) + dr);
               pb.green = clamp_comp(int'(y1_hold) - dg);
               pb.blue  = clamp_comp(int'(y1_hold) + db);
               pb.second_of_pair = 1'b1;
               pb.row_last = rlast;
               // a row index left past a shrunken row count never flags
               pb.frame_last = rlast && (at_row == rows - 1);
               convert_byte = 2;
            end
         endcase
      end

      // rows always restart at the stride, padding included
      at_byte++;
      if (at_byte >= stride) begin
         at_byte = 0;
         at_row++;
         if (at_row >= rows) at_row = 0;
      end
   endfunction

   // Offers one byte after a gap; called and returns at a rising edge.
   task automatic send_byte(input logic [7:0] b, input logic fs, input int gap,
                            input logic known, input rsp_payload_type ka,
                            input rsp_payload_type kb);
      rsp_payload_type pa, pb;
      logic            in_span;
      int              n;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{src_byte: b, frame_start: fs};
      do @(posedge clock); while (!req_ready);
      n = convert_byte(b, fs, pa, pb, in_span);
      if (known) begin
         pa = ka;
         pb = kb;
      end
      if (n == 2) begin
         pending_pixels.push_back(pa);
         pending_pixels.push_back(pb);
      end
      bytes_sent++;
      if (in_span) span_bytes++;
   endtask

   // Sender holds off until every predicted pixel is out, then waits a settle
   // margin so the pair register and pixel queue are empty too.
   task automatic wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write, then read back through the same address.
   task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
      logic [14:0]       mask;
      logic [DATA_W-1:0] got;
      mask = (idx == REG_ROW_STRIDE) ? WIDE_MASK : PX_MASK;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= DATA_W'(val & mask);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_ROW_PIXELS: cfg_px = val[12:0];
         REG_ROW_STRIDE: cfg_stride = val;
         REG_FRAME_ROWS: cfg_rows = val[12:0];
         default: ;
      endcase
      reg_writes++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== DATA_W'(val & mask))
         flag_error($sformatf("register %0d reads %0h, wrote %0h", idx, got,
                              val & mask));
   endtask

   // Pixel side: random stalls after each transfer, in bursts of 32 pixels
   // that either stall or stream; every transfer is checked in order.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         pixels_checked++;
         if (pending_pixels.size() == 0) begin
            flag_error($sformatf("pixel with nothing pending: %s", pix_str(rsp_data)));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data !== want)
               flag_error($sformatf("pixel %0d want %s got %s", pixels_checked,
                                    pix_str(want), pix_str(rsp_data)));
         end
         if (pixels_checked % 32 == 0) stall_mode = 1'($urandom_range(0, 1));
         stall_left = stall_mode ? $urandom_range(0, MAX_GAP) : 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_ready <= !reset && (stall_left == 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels pending", cycle_count,
                  pending_pixels.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int          phase, n_items, gap, px, st, rw;
      logic        fs, idle_on, every_reg;
      logic [7:0]  b;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk; first rows run on the reset geometry
      foreach (dir_tab[k]) begin
         if (dir_tab[k].kind == ROW_WRITE) begin
            wait_idle();
            write_reg(dir_tab[k].reg_sel, dir_tab[k].reg_val);
         end else begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, MAX_GAP);
            send_byte(dir_tab[k].src_byte, dir_tab[k].frame_start, gap,
                      dir_tab[k].known, dir_tab[k].pix_a, dir_tab[k].pix_b);
         end
      end

      // Random phases: a new geometry each time, written while idle. The
      // stream position carries over, so a shrunken stride or row count
      // lands mid-row and mid-frame.
      phase = 0;
      while ((bytes_sent < ITEM_TARGET || phase < MIN_PHASES) && phase < MAX_PHASES) begin
         every_reg = 1'b1;
         if (phase == 0) begin
            px = 2; st = 4; rw = 1;              // smallest legal geometry
         end else if (phase == 3) begin
            px = 4096; st = 16384; rw = 4096;    // top of the legal range
         end else if (phase == 6) begin
            px = 8191; st = 32767; rw = 8191;    // past every cap
         end else if (phase == 9) begin
            px = 0; st = 0; rw = 0;              // no pairs, stride and rows raised
         end else begin
            every_reg = 1'b0;
            px = $urandom_range(1, 13);
            case ($urandom_range(0, 3))
               0: st = $urandom_range(0, 3);
               1: st = (px / 2) * 4;
               2: st = (px / 2) * 4 + $urandom_range(1, 8);
               default: st = $urandom_range(4, 30);
            endcase
            rw = $urandom_range(0, 4);
         end

         wait_idle();
         if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_ROW_PIXELS, 15'(px));
         if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_ROW_STRIDE, 15'(st));
         if (every_reg || $urandom_range(0, 3) != 0) write_reg(REG_FRAME_ROWS, 15'(rw));

         // huge rows only get a short burst
         n_items = (phase == 3 || phase == 6) ? 24 : $urandom_range(20, 60);
         idle_on = ($urandom_range(0, 2) != 0);
         for (int i = 0; i < n_items; i++) begin
            fs = (i == 0 && $urandom_range(0, 1)) || ($urandom_range(0, 63) == 0);
            case ($urandom_range(0, 9))
               0: b = 8'd0;
               1: b = 8'd255;
               2: b = 8'd128;
               default: b = 8'($urandom_range(0, 255));
            endcase
            gap = (idle_on && $urandom_range(0, 1)) ? $urandom_range(0, MAX_GAP) : 0;
            send_byte(b, fs, gap, 1'b0, NO_PIX, NO_PIX);
         end
         phase++;
      end

      wait_idle();
      if (pending_pixels.size() != 0)
         flag_error($sformatf("%0d pixels never arrived", pending_pixels.size()));

      $display("Run: %0d source bytes (%0d in pair spans), %0d pixels checked, %0d errors",
               bytes_sent, span_bytes, pixels_checked, error_count);
      $display("Run: %0d geometries, %0d register writes; odd widths, clamped strides and rows",
               phase, reg_writes);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
